### sv/ipsc_pkg.sv
// shared widths, constants, codes and types for the inverse park / svpwm compare pipeline
package ipsc_pkg;

    localparam int VOLTAGE_WIDTH       = 16;
    localparam int ANGLE_WIDTH         = 16;
    localparam int ANGLE_FRACTION_BITS = 15;

    // rotator products, sector projections, dwell numerators
    localparam int PRW = VOLTAGE_WIDTH + ANGLE_WIDTH;
    localparam int PW  = VOLTAGE_WIDTH + 16;
    localparam int MW  = PW - 1;
    localparam int DW  = PW;

    localparam int QW  = 16;            // period and quotient width
    localparam int UW  = 15;            // bus voltage width
    localparam int KW  = 15;            // sqrt(3) constant width
    localparam int NW  = DW + QW - 1;   // dividend width
    localparam int SPW = NW + KW;
    localparam int SMW = DW + KW;

    localparam logic [KW-1:0] SQRT3_Q14 = 15'd28378;
    localparam int ONE_Q14_SHIFT = 14;
    localparam int DEN_SHIFT     = 29;
    localparam int NUW           = SPW - DEN_SHIFT;

    // stage numbering: 0..6 front end, then the quotient stages, then the output stage
    localparam int DIV_FIRST = 7;
    localparam int NST       = DIV_FIRST + QW + 1;

    localparam logic [2:0] SECTOR_1 = 3'd1;
    localparam logic [2:0] SECTOR_2 = 3'd2;
    localparam logic [2:0] SECTOR_3 = 3'd3;
    localparam logic [2:0] SECTOR_4 = 3'd4;
    localparam logic [2:0] SECTOR_5 = 3'd5;
    localparam logic [2:0] SECTOR_6 = 3'd6;

    localparam logic REG_PWM_PERIOD  = 1'b0;
    localparam logic REG_BUS_VOLTAGE = 1'b1;

    localparam logic [QW-1:0] PWM_PERIOD_RESET  = 16'd8500;
    localparam logic [UW-1:0] BUS_VOLTAGE_RESET = 15'd24000;

    typedef struct packed {
        logic [2:0] sector;
        logic       over;
    } t_side;

endpackage

### sv/ipsc_div.sv
// pipelined restoring divider, two dividends over one shared divisor, one quotient bit per stage
module ipsc_div (
    input  logic                        i_clk,
    input  logic [ipsc_pkg::QW-1:0]     i_en,
    input  logic [ipsc_pkg::NW-1:0]     i_num1,
    input  logic [ipsc_pkg::NW-1:0]     i_num2,
    input  logic [ipsc_pkg::DW-1:0]     i_den,
    input  ipsc_pkg::t_side             i_side,
    output logic [ipsc_pkg::QW-1:0]     o_quo1,
    output logic [ipsc_pkg::QW-1:0]     o_quo2,
    output ipsc_pkg::t_side             o_side
);

    logic [ipsc_pkg::NW-1:0] r_rem1  [ipsc_pkg::QW];
    logic [ipsc_pkg::NW-1:0] r_rem2  [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] r_quo1  [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] r_quo2  [ipsc_pkg::QW];
    logic [ipsc_pkg::DW-1:0] r_den   [ipsc_pkg::QW];
    ipsc_pkg::t_side         r_side  [ipsc_pkg::QW];

    logic [ipsc_pkg::NW-1:0] n_rem1  [ipsc_pkg::QW];
    logic [ipsc_pkg::NW-1:0] n_rem2  [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] n_quo1  [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] n_quo2  [ipsc_pkg::QW];

    logic [ipsc_pkg::NW-1:0] w_prem1 [ipsc_pkg::QW];
    logic [ipsc_pkg::NW-1:0] w_prem2 [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] w_pq1   [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] w_pq2   [ipsc_pkg::QW];
    logic [ipsc_pkg::DW-1:0] w_pden  [ipsc_pkg::QW];
    logic [ipsc_pkg::NW-1:0] w_trial [ipsc_pkg::QW];
    logic [ipsc_pkg::QW-1:0] w_bit   [ipsc_pkg::QW];

    // each stage works on the registers of the stage before it
    always_comb begin
        w_prem1[0] = i_num1;
        w_prem2[0] = i_num2;
        w_pq1[0]   = '0;
        w_pq2[0]   = '0;
        w_pden[0]  = i_den;
        for (int s = 1; s < ipsc_pkg::QW; s++) begin
            w_prem1[s] = r_rem1[s-1];
            w_prem2[s] = r_rem2[s-1];
            w_pq1[s]   = r_quo1[s-1];
            w_pq2[s]   = r_quo2[s-1];
            w_pden[s]  = r_den[s-1];
        end
        for (int s = 0; s < ipsc_pkg::QW; s++) begin
            w_trial[s] = ipsc_pkg::NW'(w_pden[s]) << (ipsc_pkg::QW - 1 - s);
            w_bit[s]   = ipsc_pkg::QW'(1) << (ipsc_pkg::QW - 1 - s);
            n_rem1[s]  = w_prem1[s];
            n_quo1[s]  = w_pq1[s];
            n_rem2[s]  = w_prem2[s];
            n_quo2[s]  = w_pq2[s];
            if (w_prem1[s] >= w_trial[s]) begin
                n_rem1[s] = w_prem1[s] - w_trial[s];
                n_quo1[s] = w_pq1[s] | w_bit[s];
            end
            if (w_prem2[s] >= w_trial[s]) begin
                n_rem2[s] = w_prem2[s] - w_trial[s];
                n_quo2[s] = w_pq2[s] | w_bit[s];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_side[0] <= i_side;
        end
        for (int s = 1; s < ipsc_pkg::QW; s++) begin
            if (i_en[s]) begin
                r_side[s] <= r_side[s-1];
            end
        end
        for (int s = 0; s < ipsc_pkg::QW; s++) begin
            if (i_en[s]) begin
                r_rem1[s] <= n_rem1[s];
                r_rem2[s] <= n_rem2[s];
                r_quo1[s] <= n_quo1[s];
                r_quo2[s] <= n_quo2[s];
                r_den[s]  <= w_pden[s];
            end
        end
    end

    assign o_quo1 = r_quo1[ipsc_pkg::QW-1];
    assign o_quo2 = r_quo2[ipsc_pkg::QW-1];
    assign o_side = r_side[ipsc_pkg::QW-1];

endmodule

### sv/inverse_park_svpwm_compare.sv
// top level: inverse park rotation, sector search, dwell times and phase compare values
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_d_voltage i_q_voltage i_sine_angle i_cosine_angle
//  output    out        o_valid / i_stall   o_compare_a/b/c o_sector_number o_over_modulated
//  config    in         apb psel / penable  paddr pwdata prdata pready (0: period, 4: bus voltage)
//
// one beat per cycle sustained while i_stall is low; an accepted beat passes the seven
// front-end stages, the sixteen quotient stages of the divider and the output register.
// reset clears the valid bits and restores both registers to their reset values.
// a stage takes a beat whenever it is empty or its beat moves on, so bubbles close up
// under a stall and o_stall rises only when every stage holds a beat and i_stall is high.
module inverse_park_svpwm_compare (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [ipsc_pkg::VOLTAGE_WIDTH-1:0] i_d_voltage,
    input  logic signed [ipsc_pkg::VOLTAGE_WIDTH-1:0] i_q_voltage,
    input  logic signed [ipsc_pkg::ANGLE_WIDTH-1:0]   i_sine_angle,
    input  logic signed [ipsc_pkg::ANGLE_WIDTH-1:0]   i_cosine_angle,
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [ipsc_pkg::QW-1:0]                   o_compare_a,
    output logic [ipsc_pkg::QW-1:0]                   o_compare_b,
    output logic [ipsc_pkg::QW-1:0]                   o_compare_c,
    output logic [2:0]                                o_sector_number,
    output logic                                      o_over_modulated,
    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [2:0]                                paddr,
    input  logic [31:0]                               pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    localparam int VW  = ipsc_pkg::VOLTAGE_WIDTH;
    localparam int PRW = ipsc_pkg::PRW;
    localparam int PW  = ipsc_pkg::PW;
    localparam int MW  = ipsc_pkg::MW;
    localparam int DW  = ipsc_pkg::DW;
    localparam int NW  = ipsc_pkg::NW;
    localparam int QW  = ipsc_pkg::QW;
    localparam int UW  = ipsc_pkg::UW;
    localparam int SPW = ipsc_pkg::SPW;
    localparam int SMW = ipsc_pkg::SMW;
    localparam int NUW = ipsc_pkg::NUW;
    localparam int NST = ipsc_pkg::NST;
    localparam int DF  = ipsc_pkg::DIV_FIRST;

    localparam logic signed [PW-1:0] C_SQRT3 = PW'(ipsc_pkg::SQRT3_Q14);

    function automatic logic signed [VW-1:0] sat_volt(input logic signed [PRW:0] x);
        logic fits;
        fits = (x[PRW:VW-1] == {(PRW - VW + 2){x[PRW]}});
        if (fits) begin
            return x[VW-1:0];
        end else if (x[PRW]) begin
            return {1'b1, {(VW - 1){1'b0}}};
        end else begin
            return {1'b0, {(VW - 1){1'b1}}};
        end
    endfunction

    function automatic logic [MW-1:0] mag(input logic signed [PW-1:0] p);
        logic [PW-1:0] neg;
        neg = ~p + PW'(1);
        return p[PW-1] ? neg[MW-1:0] : p[MW-1:0];
    endfunction

    function automatic logic [QW-1:0] clamp(input logic [QW-1:0] x, input logic [QW-1:0] lim);
        return (x > lim) ? lim : x;
    endfunction

    // configuration registers
    logic [QW-1:0] r_pwm_period;
    logic [UW-1:0] r_bus_voltage;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= ipsc_pkg::PWM_PERIOD_RESET;
            r_bus_voltage <= ipsc_pkg::BUS_VOLTAGE_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                ipsc_pkg::REG_PWM_PERIOD:  r_pwm_period  <= pwdata[QW-1:0];
                ipsc_pkg::REG_BUS_VOLTAGE: r_bus_voltage <= pwdata[UW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ipsc_pkg::REG_PWM_PERIOD:  prdata = 32'(r_pwm_period);
            ipsc_pkg::REG_BUS_VOLTAGE: prdata = 32'(r_bus_voltage);
            default:                   prdata = '0;
        endcase
    end

    // valid bits and per-stage enables
    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_en;

    for (genvar k = 0; k < NST; k++) begin : g_en
        assign w_en[k] = !i_stall || !(&r_vld[NST-1:k]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NST-1];

    // stage 0: rotator products
    logic signed [PRW-1:0] r0_dc, r0_qs, r0_ds, r0_qc;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_dc <= PRW'(i_d_voltage) * PRW'(i_cosine_angle);
            r0_qs <= PRW'(i_q_voltage) * PRW'(i_sine_angle);
            r0_ds <= PRW'(i_d_voltage) * PRW'(i_sine_angle);
            r0_qc <= PRW'(i_q_voltage) * PRW'(i_cosine_angle);
        end
    end

    // stage 1: alpha and beta, floor shift and saturation
    logic signed [PRW:0]   w_al_raw, w_be_raw, w_al_sh, w_be_sh;
    logic signed [VW-1:0]  r1_alpha, r1_beta;

    assign w_al_raw = {r0_dc[PRW-1], r0_dc} - {r0_qs[PRW-1], r0_qs};
    assign w_be_raw = {r0_ds[PRW-1], r0_ds} + {r0_qc[PRW-1], r0_qc};
    assign w_al_sh  = w_al_raw >>> ipsc_pkg::ANGLE_FRACTION_BITS;
    assign w_be_sh  = w_be_raw >>> ipsc_pkg::ANGLE_FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_alpha <= sat_volt(w_al_sh);
            r1_beta  <= sat_volt(w_be_sh);
        end
    end

    // stage 2: sector projections in q14, twice the reference phase voltages
    logic signed [PW-1:0] w_alpha_ext, w_beta_ext, w_sa, w_b14;
    logic signed [PW-1:0] r2_p1, r2_p2, r2_p3;

    assign w_alpha_ext = {{(PW - VW){r1_alpha[VW-1]}}, r1_alpha};
    assign w_beta_ext  = {{(PW - VW){r1_beta[VW-1]}}, r1_beta};
    assign w_sa        = C_SQRT3 * w_alpha_ext;
    assign w_b14       = w_beta_ext <<< ipsc_pkg::ONE_Q14_SHIFT;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_p1 <= w_beta_ext <<< (ipsc_pkg::ONE_Q14_SHIFT + 1);
            r2_p2 <= w_sa - w_b14;
            r2_p3 <= -w_sa - w_b14;
        end
    end

    // stage 3: sector from sign tests and dwell numerator magnitudes
    logic [2:0]    w_code, n3_sector;
    logic [MW-1:0] n3_m1, n3_m2;
    logic [2:0]    r3_sector;
    logic [MW-1:0] r3_m1, r3_m2;

    assign w_code = {(!r2_p3[PW-1] && r2_p3 != '0),
                     (!r2_p2[PW-1] && r2_p2 != '0),
                     (!r2_p1[PW-1] && r2_p1 != '0)};

    // zero vector and the impossible all-positive code fall to sector 6
    always_comb begin
        case (w_code)
            ipsc_pkg::SECTOR_1: begin
                n3_sector = ipsc_pkg::SECTOR_1; n3_m1 = mag(r2_p2); n3_m2 = mag(r2_p3);
            end
            ipsc_pkg::SECTOR_2: begin
                n3_sector = ipsc_pkg::SECTOR_2; n3_m1 = mag(r2_p3); n3_m2 = mag(r2_p1);
            end
            ipsc_pkg::SECTOR_3: begin
                n3_sector = ipsc_pkg::SECTOR_3; n3_m1 = mag(r2_p2); n3_m2 = mag(r2_p1);
            end
            ipsc_pkg::SECTOR_4: begin
                n3_sector = ipsc_pkg::SECTOR_4; n3_m1 = mag(r2_p1); n3_m2 = mag(r2_p2);
            end
            ipsc_pkg::SECTOR_5: begin
                n3_sector = ipsc_pkg::SECTOR_5; n3_m1 = mag(r2_p1); n3_m2 = mag(r2_p3);
            end
            default: begin
                n3_sector = ipsc_pkg::SECTOR_6; n3_m1 = mag(r2_p3); n3_m2 = mag(r2_p2);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_sector <= n3_sector;
            r3_m1     <= n3_m1;
            r3_m2     <= n3_m2;
        end
    end

    // stage 4: numerator sum and products with the period
    logic [2:0]    r4_sector;
    logic [DW-1:0] r4_sum;
    logic [NW-1:0] r4_pr1, r4_pr2;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_sector <= r3_sector;
            r4_sum    <= DW'(r3_m1) + DW'(r3_m2);
            r4_pr1    <= NW'(r3_m1) * NW'(r_pwm_period);
            r4_pr2    <= NW'(r3_m2) * NW'(r_pwm_period);
        end
    end

    // stage 5: scaling by sqrt(3) for the limit test and the unscaled dwell times
    logic [SPW-1:0] w_spk1, w_spk2;
    logic [2:0]     r5_sector;
    logic [DW-1:0]  r5_sum;
    logic [NW-1:0]  r5_pr1, r5_pr2;
    logic [SMW-1:0] r5_sm;
    logic [NUW-1:0] r5_nu1, r5_nu2;

    assign w_spk1 = SPW'(ipsc_pkg::SQRT3_Q14) * SPW'(r4_pr1);
    assign w_spk2 = SPW'(ipsc_pkg::SQRT3_Q14) * SPW'(r4_pr2);

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_sector <= r4_sector;
            r5_sum    <= r4_sum;
            r5_pr1    <= r4_pr1;
            r5_pr2    <= r4_pr2;
            r5_sm     <= SMW'(ipsc_pkg::SQRT3_Q14) * SMW'(r4_sum);
            r5_nu1    <= w_spk1[SPW-1:ipsc_pkg::DEN_SHIFT];
            r5_nu2    <= w_spk2[SPW-1:ipsc_pkg::DEN_SHIFT];
        end
    end

    // stage 6: over-modulation test, pick dividend and divisor
    logic [UW-1:0]   w_u;
    logic [SMW-1:0]  w_den_u;
    logic            w_over;
    logic [NW-1:0]   r6_num1, r6_num2;
    logic [DW-1:0]   r6_den;
    ipsc_pkg::t_side r6_side;

    assign w_u     = (r_bus_voltage == '0) ? UW'(1) : r_bus_voltage;
    assign w_den_u = SMW'(w_u) << ipsc_pkg::DEN_SHIFT;
    assign w_over  = r5_sm > w_den_u;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_num1        <= w_over ? r5_pr1 : NW'(r5_nu1);
            r6_num2        <= w_over ? r5_pr2 : NW'(r5_nu2);
            r6_den         <= w_over ? r5_sum : DW'(w_u);
            r6_side.sector <= r5_sector;
            r6_side.over   <= w_over;
        end
    end

    // stages 7..22: quotients t1 and t2
    logic [QW-1:0]   w_t1, w_t2;
    ipsc_pkg::t_side w_side;

    ipsc_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en[DF+QW-1:DF]),
        .i_num1 (r6_num1),
        .i_num2 (r6_num2),
        .i_den  (r6_den),
        .i_side (r6_side),
        .o_quo1 (w_t1),
        .o_quo2 (w_t2),
        .o_side (w_side)
    );

    // stage 23: seven-segment timing and phase assignment
    logic [QW-1:0] w_rest, w_ta, w_tb, w_tc, w_ca, w_cb, w_cc;

    assign w_rest = r_pwm_period - w_t1 - w_t2;
    assign w_ta   = w_rest >> 2;
    assign w_tb   = w_ta + (w_t1 >> 1);
    assign w_tc   = w_tb + (w_t2 >> 1);

    always_comb begin
        case (w_side.sector)
            ipsc_pkg::SECTOR_1: begin w_ca = w_tb; w_cb = w_ta; w_cc = w_tc; end
            ipsc_pkg::SECTOR_2: begin w_ca = w_ta; w_cb = w_tc; w_cc = w_tb; end
            ipsc_pkg::SECTOR_3: begin w_ca = w_ta; w_cb = w_tb; w_cc = w_tc; end
            ipsc_pkg::SECTOR_4: begin w_ca = w_tc; w_cb = w_tb; w_cc = w_ta; end
            ipsc_pkg::SECTOR_5: begin w_ca = w_tc; w_cb = w_ta; w_cc = w_tb; end
            default:            begin w_ca = w_tb; w_cb = w_tc; w_cc = w_ta; end
        endcase
    end

    logic [QW-1:0] r_cmp_a, r_cmp_b, r_cmp_c;
    logic [2:0]    r_sector;
    logic          r_over;

    always_ff @(posedge i_clk) begin
        if (w_en[NST-1]) begin
            r_cmp_a  <= clamp(w_ca, r_pwm_period);
            r_cmp_b  <= clamp(w_cb, r_pwm_period);
            r_cmp_c  <= clamp(w_cc, r_pwm_period);
            r_sector <= w_side.sector;
            r_over   <= w_side.over;
        end
    end

    assign o_compare_a      = r_cmp_a;
    assign o_compare_b      = r_cmp_b;
    assign o_compare_c      = r_cmp_c;
    assign o_sector_number  = r_sector;
    assign o_over_modulated = r_over;

    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sector_number >= ipsc_pkg::SECTOR_1 &&
                     o_sector_number <= ipsc_pkg::SECTOR_6))
        else $error("sector out of range on a valid beat");

    a_compare_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_compare_a <= r_pwm_period && o_compare_b <= r_pwm_period &&
                     o_compare_c <= r_pwm_period))
        else $error("compare value above the period");

    a_sector3_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sector_number == ipsc_pkg::SECTOR_3) |->
            (o_compare_a <= o_compare_b && o_compare_b <= o_compare_c))
        else $error("sector 3 compares out of order");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    a_output_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !r_vld[NST-2]) |=> !o_valid)
        else $error("result beat repeated after it was taken");

endmodule

### bench/inverse_park_svpwm_compare_tb.sv
`timescale 1ns / 1ps
// testbench for the inverse park / svpwm compare pipeline: directed, register and random beats
module inverse_park_svpwm_compare_tb;

    localparam int LATENCY     = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    localparam longint ROOT3   = longint'(ipsc_pkg::SQRT3_Q14);
    localparam longint ONE_Q14 = longint'(1) << ipsc_pkg::ONE_Q14_SHIFT;
    localparam longint V_MAX   = (longint'(1) << (ipsc_pkg::VOLTAGE_WIDTH - 1)) - 1;
    localparam longint V_MIN   = -(longint'(1) << (ipsc_pkg::VOLTAGE_WIDTH - 1));

    localparam logic [2:0] ADDR_PERIOD = {ipsc_pkg::REG_PWM_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_BUS    = {ipsc_pkg::REG_BUS_VOLTAGE, 2'b00};

    typedef struct packed {
        logic [ipsc_pkg::QW-1:0] a;
        logic [ipsc_pkg::QW-1:0] b;
        logic [ipsc_pkg::QW-1:0] c;
        logic [2:0]              sector;
        logic                    over;
    } t_compares;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [ipsc_pkg::VOLTAGE_WIDTH-1:0] i_d_voltage    = '0;
    logic signed [ipsc_pkg::VOLTAGE_WIDTH-1:0] i_q_voltage    = '0;
    logic signed [ipsc_pkg::ANGLE_WIDTH-1:0]   i_sine_angle   = '0;
    logic signed [ipsc_pkg::ANGLE_WIDTH-1:0]   i_cosine_angle = '0;
    logic                    o_stall;
    logic                    o_valid;
    logic [ipsc_pkg::QW-1:0] o_compare_a;
    logic [ipsc_pkg::QW-1:0] o_compare_b;
    logic [ipsc_pkg::QW-1:0] o_compare_c;
    logic [2:0]              o_sector_number;
    logic                    o_over_modulated;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [2:0]              paddr   = '0;
    logic [31:0]             pwdata  = '0;
    logic [31:0]             prdata;
    logic                    pready;

    logic [ipsc_pkg::QW-1:0] period_setting = ipsc_pkg::PWM_PERIOD_RESET;
    logic [ipsc_pkg::UW-1:0] bus_setting    = ipsc_pkg::BUS_VOLTAGE_RESET;

    t_compares pending_compares[$];
    int mismatches   = 0;
    bit stall_bursts = 1'b0;
    bit send_gaps    = 1'b0;
    int hold_cycles  = 0;
    int stall_left   = 0;

    inverse_park_svpwm_compare DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_d_voltage      (i_d_voltage),
        .i_q_voltage      (i_q_voltage),
        .i_sine_angle     (i_sine_angle),
        .i_cosine_angle   (i_cosine_angle),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_compare_a      (o_compare_a),
        .o_compare_b      (o_compare_b),
        .o_compare_c      (o_compare_c),
        .o_sector_number  (o_sector_number),
        .o_over_modulated (o_over_modulated),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint clip_voltage(input longint x);
        if (x > V_MAX) return V_MAX;
        if (x < V_MIN) return V_MIN;
        return x;
    endfunction

    function automatic logic [63:0] magnitude(input longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    // expected compares for one beat under the current register settings
    function automatic t_compares predict_compares(input logic signed [15:0] d, q, sn, cs);
        longint      alpha, beta, p1, p2, p3;
        logic [63:0] m1, m2, t1, t2, ta, tb, tc, ca, cb, cc, den, per, root3;
        logic [2:0]  sector;
        t_compares   r;
        root3 = 64'(ipsc_pkg::SQRT3_Q14);
        per   = 64'(period_setting);
        den   = (bus_setting == '0) ? (64'd1 << ipsc_pkg::DEN_SHIFT)
                                    : (64'(bus_setting) << ipsc_pkg::DEN_SHIFT);
        alpha = (longint'(d) * longint'(cs) - longint'(q) * longint'(sn))
                >>> ipsc_pkg::ANGLE_FRACTION_BITS;
        beta  = (longint'(d) * longint'(sn) + longint'(q) * longint'(cs))
                >>> ipsc_pkg::ANGLE_FRACTION_BITS;
        alpha = clip_voltage(alpha);
        beta  = clip_voltage(beta);
        p1 = beta * (2 * ONE_Q14);
        p2 = ROOT3 * alpha - beta * ONE_Q14;
        p3 = -ROOT3 * alpha - beta * ONE_Q14;
        sector = {p3 > 0, p2 > 0, p1 > 0};
        case (sector)
            ipsc_pkg::SECTOR_1: begin m1 = magnitude(p2); m2 = magnitude(p3); end
            ipsc_pkg::SECTOR_2: begin m1 = magnitude(p3); m2 = magnitude(p1); end
            ipsc_pkg::SECTOR_3: begin m1 = magnitude(p2); m2 = magnitude(p1); end
            ipsc_pkg::SECTOR_4: begin m1 = magnitude(p1); m2 = magnitude(p2); end
            ipsc_pkg::SECTOR_5: begin m1 = magnitude(p1); m2 = magnitude(p3); end
            default: begin
                sector = ipsc_pkg::SECTOR_6;
                m1 = magnitude(p3);
                m2 = magnitude(p2);
            end
        endcase
        r.over = (root3 * (m1 + m2) > den);
        if (r.over) begin
            t1 = m1 * per / (m1 + m2);
            t2 = m2 * per / (m1 + m2);
        end else begin
            t1 = root3 * m1 * per / den;
            t2 = root3 * m2 * per / den;
        end
        ta = (per - t1 - t2) >> 2;
        tb = ta + (t1 >> 1);
        tc = tb + (t2 >> 1);
        case (sector)
            ipsc_pkg::SECTOR_1: begin ca = tb; cb = ta; cc = tc; end
            ipsc_pkg::SECTOR_2: begin ca = ta; cb = tc; cc = tb; end
            ipsc_pkg::SECTOR_3: begin ca = ta; cb = tb; cc = tc; end
            ipsc_pkg::SECTOR_4: begin ca = tc; cb = tb; cc = ta; end
            ipsc_pkg::SECTOR_5: begin ca = tc; cb = ta; cc = tb; end
            default: begin ca = tb; cb = tc; cc = ta; end
        endcase
        r.a = ipsc_pkg::QW'((ca > per) ? per : ca);
        r.b = ipsc_pkg::QW'((cb > per) ? per : cb);
        r.c = ipsc_pkg::QW'((cc > per) ? per : cc);
        r.sector = sector;
        return r;
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // mostly full-range or modest voltages, with some zero and extreme fields mixed in
    function automatic void random_beat(output logic signed [15:0] d, q, sn, cs);
        int kind;
        int r;
        kind = $urandom_range(0, 9);
        d  = 16'($urandom);
        q  = 16'($urandom);
        sn = 16'($urandom);
        cs = 16'($urandom);
        if (kind >= 4 && kind <= 7) begin
            r = 1 << $urandom_range(3, 14);
            d = 16'(int'($urandom_range(0, 2 * r)) - r);
            q = 16'(int'($urandom_range(0, 2 * r)) - r);
        end else if (kind == 8) begin
            case ($urandom_range(0, 2))
                0: d = '0;
                1: q = '0;
                default: begin
                    sn = '0;
                    cs = '0;
                end
            endcase
        end else if (kind == 9) begin
            d  = pick_extreme();
            q  = pick_extreme();
            sn = pick_extreme();
            cs = pick_extreme();
        end
    endfunction

    task automatic check_field(input string name, input longint unsigned want, got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("mismatch %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // result side: a beat moves at the next rising edge if valid is high and stall low
    always @(negedge i_clk) begin : result_check
        t_compares want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_compares.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result beat with nothing expected");
            end else begin
                want = pending_compares.pop_front();
                check_field("compare_a", 64'(want.a), 64'(o_compare_a));
                check_field("compare_b", 64'(want.b), 64'(o_compare_b));
                check_field("compare_c", 64'(want.c), 64'(o_compare_c));
                check_field("sector_number", 64'(want.sector), 64'(o_sector_number));
                check_field("over_modulated", 64'(want.over), 64'(o_over_modulated));
            end
        end
    end

    // receiver stall: a long hold when asked, else random bursts
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (stall_bursts && $urandom_range(0, 7) == 0) begin
            i_stall <= 1'b1;
            stall_left = $urandom_range(1, 10) - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("inverse_park_svpwm_compare_tb failed");
        $finish;
    end

    task automatic idle_for(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_beat(input logic signed [15:0] d, q, sn, cs);
        bit taken;
        i_valid        <= 1'b1;
        i_d_voltage    <= d;
        i_q_voltage    <= q;
        i_sine_angle   <= sn;
        i_cosine_angle <= cs;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        pending_compares.push_back(predict_compares(d, q, sn, cs));
        if (send_gaps && $urandom_range(0, 5) == 0)
            idle_for($urandom_range(1, 10));
    endtask

    task automatic send_random(input int n);
        logic signed [15:0] d, q, sn, cs;
        repeat (n) begin
            random_beat(d, q, sn, cs);
            send_beat(d, q, sn, cs);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_compares.size() != 0) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rdata);
        bit ready;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready = pready;
            rdata = prdata;
            @(posedge i_clk);
        end while (!ready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_registers(input logic [ipsc_pkg::QW-1:0] period,
                                 input logic [ipsc_pkg::UW-1:0] bus);
        logic [31:0] rdata;
        wait_idle();
        apb_access(1'b1, ADDR_PERIOD, 32'(period), rdata);
        period_setting = period;
        apb_access(1'b1, ADDR_BUS, 32'(bus), rdata);
        bus_setting = bus;
        apb_access(1'b0, ADDR_PERIOD, '0, rdata);
        check_field("pwm_period readback", 64'(period), 64'(rdata));
        apb_access(1'b0, ADDR_BUS, '0, rdata);
        check_field("bus_voltage readback", 64'(bus), 64'(rdata));
    endtask

    task automatic test_reset_values();
        logic [31:0] rdata;
        apb_access(1'b0, ADDR_PERIOD, '0, rdata);
        check_field("pwm_period after reset", 64'(ipsc_pkg::PWM_PERIOD_RESET), 64'(rdata));
        apb_access(1'b0, ADDR_BUS, '0, rdata);
        check_field("bus_voltage after reset", 64'(ipsc_pkg::BUS_VOLTAGE_RESET), 64'(rdata));
    endtask

    task automatic test_directed();
        // zero vector, from zero commands and from a zero angle vector
        send_beat(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
        send_beat(16'sd8000, 16'sd0, 16'sd0, 16'sd0);
        // one beat in the middle of each sector, below and above the modulation limit
        send_beat(16'sd8000, 16'sd0, 16'sd16384, 16'sd28378);
        send_beat(16'sd8000, 16'sd0, 16'sd32767, 16'sd0);
        send_beat(16'sd8000, 16'sd0, 16'sd16384, -16'sd28378);
        send_beat(16'sd8000, 16'sd0, -16'sd16384, -16'sd28378);
        send_beat(16'sd8000, 16'sd0, -16'sd32768, 16'sd0);
        send_beat(16'sd8000, 16'sd0, -16'sd16384, 16'sd28378);
        send_beat(16'sd0, 16'sd32767, 16'sd16384, 16'sd28378);
        send_beat(16'sd0, 16'sd32767, 16'sd32767, 16'sd0);
        send_beat(16'sd0, 16'sd32767, 16'sd16384, -16'sd28378);
        send_beat(16'sd0, 16'sd32767, -16'sd16384, -16'sd28378);
        send_beat(16'sd0, 16'sd32767, -16'sd32768, 16'sd0);
        send_beat(16'sd0, 16'sd32767, -16'sd16384, 16'sd28378);
        // rotator saturation at the field extremes
        send_beat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_beat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_beat(16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767);
        send_beat(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_beat(16'sd0, 16'sd0, -16'sd32768, -16'sd32768);
        // rounding toward minus infinity, and a beat on a sector border
        send_beat(-16'sd1, 16'sd0, 16'sd0, 16'sd32767);
        send_beat(16'sd1, 16'sd0, 16'sd0, 16'sd1);
        send_beat(16'sd100, 16'sd0, 16'sd0, 16'sd32767);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        stall_bursts = 1'b1;
        send_gaps    = 1'b1;
        set_registers(16'd1, 15'd1);
        send_random(30);
        set_registers(16'd65535, 15'd32767);
        send_random(30);
        // zero period and zero bus voltage
        set_registers(16'd0, 15'd0);
        send_random(30);
        set_registers(16'd65535, 15'd1);
        send_random(30);
        set_registers(16'd1, 15'd32767);
        send_random(30);
        set_registers(16'd0, 15'd24000);
        send_random(30);
    endtask

    task automatic test_random_phases();
        set_registers(16'($urandom_range(1, 64)), 15'($urandom_range(1, 32767)));
        send_random(170);
        repeat (4) begin
            set_registers(16'($urandom_range(1, 65535)), 15'($urandom_range(1, 32767)));
            send_random(170);
        end
        set_registers(ipsc_pkg::PWM_PERIOD_RESET, ipsc_pkg::BUS_VOLTAGE_RESET);
    endtask

    task automatic test_backpressure();
        // the receiver holds off long enough for the pipeline to fill and stall its input
        stall_bursts = 1'b0;
        send_gaps    = 1'b0;
        hold_cycles  = 300;
        send_random(80);
        stall_bursts = 1'b1;
        send_gaps    = 1'b1;
    endtask

    task automatic test_drain_pause();
        send_random(20);
        wait_idle();
        send_random(20);
    endtask

    task automatic test_quiet_tail();
        stall_bursts = 1'b0;
        send_gaps    = 1'b0;
        send_random(100);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        test_quiet_tail();
        wait_idle();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_compares.size() == 0) begin
            $display("inverse_park_svpwm_compare_tb passed");
        end else begin
            $display("inverse_park_svpwm_compare_tb failed");
        end
        $finish;
    end

endmodule
